### rtl/lqst_pkg.sv
// Shared types, constants and codes of the link quality statistics table.
// Used by the top level, the controller and the datapath; depends on nothing.
`default_nettype none
package lqst_pkg;

  localparam int MAX_PEERS    = 16;
  localparam int NUM_CHANNELS = 3;
  localparam int NUM_LINKS    = MAX_PEERS * NUM_CHANNELS;
  localparam int SLOT_W       = $clog2(MAX_PEERS);
  localparam int LINK_W       = $clog2(NUM_LINKS);
  localparam int GAP_LIMIT    = 1000;
  localparam int IN_DATA_W    = 136;
  localparam int OUT_DATA_W   = 208;

  typedef enum logic [2:0] {
    CMD_RECEIVE   = 3'd0,
    CMD_READ      = 3'd1,
    CMD_CLR_WIN   = 3'd2,
    CMD_CLR_CHAN  = 3'd3,
    CMD_CLR_ALL   = 3'd4
  } lqst_cmd_code_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_BAD_LEN = 3'd1,
    STAT_CH_OFF  = 3'd2,
    STAT_FOREIGN = 3'd3,
    STAT_FULL    = 3'd4,
    STAT_NO_ROW  = 3'd5,
    STAT_BAD_CMD = 3'd6
  } lqst_status_t;

  typedef enum logic [1:0] {
    REG_CONTENTION = 2'd0,
    REG_OWN_NODE   = 2'd1,
    REG_MAGIC      = 2'd2,
    REG_LENGTH     = 2'd3
  } lqst_reg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SEARCH, S_RESOLVE, S_RD, S_UPD, S_DIV, S_DONE
  } lqst_state_t;

  // One (peer, channel) row as stored in the statistics memory.
  typedef struct packed {
    logic [31:0] prev_seq;
    logic [31:0] rx;
    logic [31:0] miss;
    logic [31:0] win_rx;
    logic [31:0] win_miss;
    logic [31:0] total;
    logic [31:0] samples;
    logic [7:0]  recent;
    logic [7:0]  low;
    logic [7:0]  high;
    logic [7:0]  power;
    logic [31:0] heard;
  } lqst_row_t;

  localparam int ROW_W = $bits(lqst_row_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic search_clr;
    logic search_step;
    logic resolve;
    logic rd;
    logic upd;
    logic out_load;
  } lqst_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chk_final;
    logic search_done;
    logic resolve_fail;
    logic upd_fail;
    logic div_busy;
    logic out_free;
  } lqst_sts_t;

endpackage
`default_nettype wire

### rtl/link_quality_stats_table.sv
// Top level of the link quality statistics table: controller plus datapath.
// Depends on lqst_pkg, lqst_ctrl and lqst_dp (with lqst_ram and lqst_div).
//
// Usage: commands enter on the s_ stream (s_tuser carries the command code),
// one result leaves on the m_ stream per command (m_tuser carries status).
// Registers are to be written by the user through cfg_we/cfg_addr/cfg_wdata
// only while idle; the block does not enforce this. Commands settled by
// the early checks (dropped packets, clears, bad channel, unknown
// command) skip the slot search. Receive and read commands search the
// peer slots one per cycle up to a match or the last slot (all 16 for a
// new peer). A full table or an unknown peer ends at the resolve state, a
// read of a link never seen at the update state; a row result adds the
// memory read, the update and the mean divide. One command is worked on
// at a time; s_tready is high only while the controller is idle, so the
// next command is taken in the cycle after the result is loaded.
// The result sits in an output register, so the next command is taken even
// while the receiver stalls m_tready; a second result then waits until the
// first transaction completes.
// Reset (synchronous, rst high) empties the table at once through per-row
// valid flags, and restores the register defaults.
`default_nettype none
module link_quality_stats_table (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // channel[1:0], pkt_len[9:2], magic[41:10], sender_node[49:42],
  // sequence_req[81:50], sender_dbm[89:82], rssi[97:90], time_ms[129:98]
  input  wire logic [135:0] s_tdata,
  // command[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // peer_id[7:0], rx_total[39:8], missed_total[71:40], window_rx[103:72],
  // window_missed[135:104], rssi_last_out[143:136], rssi_mean[151:144],
  // rssi_min_out[159:152], rssi_max_out[167:160], last_heard_ms[199:168],
  // peer_power[207:200]
  output logic [207:0]      m_tdata,
  // status[2:0]
  output logic [2:0]        m_tuser
);
  lqst_pkg::lqst_ctl_t ctl;
  lqst_pkg::lqst_sts_t sts;

  lqst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_tvalid && s_tready),
    .sts      (sts),
    .in_ready (s_tready),
    .ctl      (ctl)
  );

  lqst_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (s_tuser),
    .in_data    (s_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_data   (m_tdata)
  );
endmodule
`default_nettype wire

### rtl/lqst_ram.sv
// Generic single-write, single-read memory with registered read data.
// Stand-alone; no package needed.
`default_nettype none
module lqst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/lqst_div.sv
// Unsigned 32 by 32 restoring divider, one quotient bit per cycle.
// Stand-alone; used by the datapath for the mean RSSI.
`default_nettype none
module lqst_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic [32:0] trial;

  // Trial subtraction of the shifted remainder.
  assign trial = {rem, quotient[31]} - {1'b0, dsr};

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'd1) begin
      busy <= 1'b0;
    end
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
      cnt      <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### rtl/lqst_ctrl.sv
// Sequencing state machine of the statistics table.
// Depends on lqst_pkg for the state type and command/status structs.
`default_nettype none
module lqst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire lqst_pkg::lqst_sts_t sts,
  output logic                   in_ready,
  output lqst_pkg::lqst_ctl_t    ctl
);
  lqst_pkg::lqst_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lqst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      lqst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctl.load   = 1'b1;
          state_next = lqst_pkg::S_CHECK;
        end
      end
      lqst_pkg::S_CHECK: begin
        ctl.check      = 1'b1;
        ctl.search_clr = 1'b1;
        state_next = sts.chk_final ? lqst_pkg::S_DONE : lqst_pkg::S_SEARCH;
      end
      lqst_pkg::S_SEARCH: begin
        ctl.search_step = 1'b1;
        if (sts.search_done) begin
          state_next = lqst_pkg::S_RESOLVE;
        end
      end
      lqst_pkg::S_RESOLVE: begin
        ctl.resolve = 1'b1;
        state_next = sts.resolve_fail ? lqst_pkg::S_DONE : lqst_pkg::S_RD;
      end
      lqst_pkg::S_RD: begin
        ctl.rd     = 1'b1;
        state_next = lqst_pkg::S_UPD;
      end
      lqst_pkg::S_UPD: begin
        ctl.upd    = 1'b1;
        state_next = sts.upd_fail ? lqst_pkg::S_DONE : lqst_pkg::S_DIV;
      end
      lqst_pkg::S_DIV: begin
        if (!sts.div_busy) begin
          state_next = lqst_pkg::S_DONE;
        end
      end
      lqst_pkg::S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = lqst_pkg::S_IDLE;
        end
      end
      default: state_next = lqst_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/lqst_dp.sv
// Datapath: configuration, peer slots, row valid flags, row memory, row
// update, mean divider and the output register. Depends on lqst_pkg,
// lqst_ram and lqst_div.
`default_nettype none
module lqst_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_addr,
  input  wire logic [31:0]                       cfg_wdata,
  input  wire logic [2:0]                        in_cmd,
  input  wire logic [lqst_pkg::IN_DATA_W-1:0]    in_data,
  input  wire lqst_pkg::lqst_ctl_t               ctl,
  output lqst_pkg::lqst_sts_t                    sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [2:0]                             out_status,
  output logic [lqst_pkg::OUT_DATA_W-1:0]        out_data
);
  localparam int SW = lqst_pkg::SLOT_W;
  localparam int LW = lqst_pkg::LINK_W;

  // Configuration registers.
  logic [2:0]  contention_mode;
  logic [7:0]  own_node;
  logic [31:0] packet_magic;
  logic [7:0]  packet_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      contention_mode <= '0;
      own_node        <= 8'd1;
      packet_magic    <= '0;
      packet_length   <= '0;
    end else if (cfg_we) begin
      unique case (lqst_pkg::lqst_reg_t'(cfg_addr))
        lqst_pkg::REG_CONTENTION: contention_mode <= cfg_wdata[2:0];
        lqst_pkg::REG_OWN_NODE:   own_node        <= cfg_wdata[7:0];
        lqst_pkg::REG_MAGIC:      packet_magic    <= cfg_wdata;
        lqst_pkg::REG_LENGTH:     packet_length   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic [2:0]  cmd_q;
  logic [1:0]  ch_q;
  logic [7:0]  len_q;
  logic [31:0] magic_q;
  logic [7:0]  node_q;
  logic [31:0] seq_q;
  logic [7:0]  dbm_q;
  logic [7:0]  rssi_q;
  logic [31:0] time_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= in_cmd;
      ch_q    <= in_data[1:0];
      len_q   <= in_data[9:2];
      magic_q <= in_data[41:10];
      node_q  <= in_data[49:42];
      seq_q   <= in_data[81:50];
      dbm_q   <= in_data[89:82];
      rssi_q  <= in_data[97:90];
      time_q  <= in_data[129:98];
    end
  end

  logic is_rx;
  logic ch_bad;
  logic ch_on;
  assign is_rx  = (cmd_q == lqst_pkg::CMD_RECEIVE);
  assign ch_bad = (int'(ch_q) >= lqst_pkg::NUM_CHANNELS);

  // Channel enable under the contention mode.
  always_comb begin
    if (contention_mode == 3'd0) begin
      ch_on = 1'b1;
    end else if (contention_mode == 3'd4) begin
      ch_on = (ch_q == 2'd0);
    end else begin
      ch_on = (contention_mode == {1'b0, ch_q} + 3'd1);
    end
  end

  // Early checks that settle the result before any slot search.
  logic [2:0] chk_status;
  logic       chk_final;
  always_comb begin
    chk_status = lqst_pkg::STAT_OK;
    chk_final  = 1'b1;
    unique case (cmd_q) inside
      lqst_pkg::CMD_RECEIVE: begin
        if (len_q != packet_length || ch_bad) begin
          chk_status = lqst_pkg::STAT_BAD_LEN;
        end else if (!ch_on) begin
          chk_status = lqst_pkg::STAT_CH_OFF;
        end else if (magic_q != packet_magic || node_q == own_node) begin
          chk_status = lqst_pkg::STAT_FOREIGN;
        end else begin
          chk_final = 1'b0;
        end
      end
      lqst_pkg::CMD_READ: begin
        if (ch_bad) begin
          chk_status = lqst_pkg::STAT_BAD_LEN;
        end else begin
          chk_final = 1'b0;
        end
      end
      lqst_pkg::CMD_CLR_WIN, lqst_pkg::CMD_CLR_ALL: chk_status = lqst_pkg::STAT_OK;
      lqst_pkg::CMD_CLR_CHAN: begin
        if (ch_bad) begin
          chk_status = lqst_pkg::STAT_BAD_LEN;
        end
      end
      default: chk_status = lqst_pkg::STAT_BAD_CMD;
    endcase
  end

  // Peer slot table and slot search.
  logic          slot_used [lqst_pkg::MAX_PEERS];
  logic [7:0]    slot_node [lqst_pkg::MAX_PEERS];
  logic [SW-1:0] idx;
  logic          hit;
  logic [SW-1:0] hit_slot;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic [SW-1:0] sel;
  logic          match_now;
  logic          resolve_fail;

  assign match_now    = slot_used[idx] && slot_node[idx] == node_q;
  assign resolve_fail = !hit && !(is_rx && free_found);

  // Per-row valid flags: a row that is not valid reads as zero but for low=127,
  // high=-128; a row whose window flag is clear has zero window counters.
  logic          link_valid [lqst_pkg::NUM_LINKS];
  logic          win_valid  [lqst_pkg::NUM_LINKS];
  logic [LW-1:0] row_addr;
  logic          lv;
  logic          wv;
  assign row_addr = LW'(sel) * LW'(lqst_pkg::NUM_CHANNELS) + LW'(ch_q);
  assign lv       = link_valid[row_addr];
  assign wv       = win_valid[row_addr];

  lqst_pkg::lqst_row_t rdata;
  lqst_pkg::lqst_row_t base;
  lqst_pkg::lqst_row_t nrow;
  lqst_pkg::lqst_row_t row_q;
  logic                ram_we;

  lqst_ram #(.WIDTH(lqst_pkg::ROW_W), .DEPTH(lqst_pkg::NUM_LINKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_addr),
    .wdata (nrow),
    .re    (ctl.rd),
    .raddr (row_addr),
    .rdata (rdata)
  );

  // Row as last stored, and the row after folding in this packet.
  logic [31:0] gap;
  logic        gap_count;
  logic [31:0] lost;
  always_comb begin
    base = lv ? rdata : '0;
    if (!(lv && wv)) begin
      base.win_rx   = '0;
      base.win_miss = '0;
    end
    if (!lv) begin
      base.low  = 8'sd127;
      base.high = 8'h80;
    end
    gap       = seq_q - base.prev_seq;
    gap_count = lv && gap > 32'd1 && gap < 32'(lqst_pkg::GAP_LIMIT);
    lost      = gap_count ? gap - 32'd1 : 32'd0;
    nrow          = base;
    nrow.miss     = base.miss + lost;
    nrow.win_miss = base.win_miss + lost;
    nrow.prev_seq = seq_q;
    nrow.rx       = base.rx + 32'd1;
    nrow.win_rx   = base.win_rx + 32'd1;
    nrow.recent   = rssi_q;
    nrow.total    = base.total + {{24{rssi_q[7]}}, rssi_q};
    nrow.samples  = base.samples + 32'd1;
    if ($signed(rssi_q) < $signed(base.low)) begin
      nrow.low = rssi_q;
    end
    if ($signed(rssi_q) > $signed(base.high)) begin
      nrow.high = rssi_q;
    end
    nrow.power = dbm_q;
    nrow.heard = time_q;
  end

  logic upd_fail;
  assign upd_fail = !is_rx && !lv;
  assign ram_we   = ctl.upd && is_rx;

  // Mean RSSI divider on the magnitude of the total.
  lqst_pkg::lqst_row_t div_row;
  logic [31:0] div_mag;
  logic        div_busy;
  logic [31:0] quot;
  logic        neg_q;
  assign div_row = is_rx ? nrow : base;
  assign div_mag = div_row.total[31] ? (32'd0 - div_row.total) : div_row.total;

  lqst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.upd && !upd_fail),
    .dividend (div_mag),
    .divisor  (div_row.samples),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Status, search, slot and flag updates.
  logic [2:0] status_q;
  logic       has_row;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lqst_pkg::MAX_PEERS; i++) begin
        slot_used[i] <= 1'b0;
      end
      for (int k = 0; k < lqst_pkg::NUM_LINKS; k++) begin
        link_valid[k] <= 1'b0;
        win_valid[k]  <= 1'b0;
      end
    end else begin
      if (ctl.check && chk_status == lqst_pkg::STAT_OK) begin
        unique case (cmd_q)
          lqst_pkg::CMD_CLR_WIN: begin
            for (int k = 0; k < lqst_pkg::NUM_LINKS; k++) begin
              win_valid[k] <= 1'b0;
            end
          end
          lqst_pkg::CMD_CLR_CHAN: begin
            for (int k = 0; k < lqst_pkg::NUM_LINKS; k++) begin
              if ((k % lqst_pkg::NUM_CHANNELS) == int'(ch_q)) begin
                link_valid[k] <= 1'b0;
              end
            end
          end
          lqst_pkg::CMD_CLR_ALL: begin
            for (int i = 0; i < lqst_pkg::MAX_PEERS; i++) begin
              slot_used[i] <= 1'b0;
            end
            for (int k = 0; k < lqst_pkg::NUM_LINKS; k++) begin
              link_valid[k] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (ctl.resolve && !hit && is_rx && free_found) begin
        slot_used[free_slot] <= 1'b1;
      end
      if (ram_we) begin
        link_valid[row_addr] <= 1'b1;
        win_valid[row_addr]  <= 1'b1;
      end
    end
    if (ctl.resolve && !hit && is_rx && free_found) begin
      slot_node[free_slot] <= node_q;
    end
    if (ctl.check) begin
      status_q <= chk_status;
      has_row  <= 1'b0;
    end
    if (ctl.search_clr) begin
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (ctl.search_step) begin
      idx <= idx + SW'(1);
      if (match_now) begin
        hit      <= 1'b1;
        hit_slot <= idx;
      end else if (!slot_used[idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
    end
    if (ctl.resolve) begin
      if (hit) begin
        sel <= hit_slot;
      end else if (is_rx && free_found) begin
        sel <= free_slot;
      end else begin
        status_q <= is_rx ? lqst_pkg::STAT_FULL : lqst_pkg::STAT_NO_ROW;
      end
    end
    if (ctl.upd) begin
      if (upd_fail) begin
        status_q <= lqst_pkg::STAT_NO_ROW;
      end else begin
        has_row <= 1'b1;
        row_q   <= div_row;
        neg_q   <= div_row.total[31];
      end
    end
  end

  // Mean, zero when the row has no samples.
  logic [7:0] mean;
  logic [31:0] signed_q;
  assign signed_q = neg_q ? (32'd0 - quot) : quot;
  assign mean     = (row_q.samples == 32'd0) ? 8'd0 : signed_q[7:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.out_load) begin
      out_status <= status_q;
      if (has_row) begin
        out_data <= {row_q.power, row_q.heard, row_q.high, row_q.low, mean,
                     row_q.recent, row_q.win_miss, row_q.win_rx, row_q.miss,
                     row_q.rx, node_q};
      end else begin
        out_data <= '0;
      end
    end
  end

  assign sts.chk_final    = chk_final;
  assign sts.search_done  = match_now || idx == SW'(lqst_pkg::MAX_PEERS - 1);
  assign sts.resolve_fail = resolve_fail;
  assign sts.upd_fail     = upd_fail;
  assign sts.div_busy     = div_busy;
  assign sts.out_free     = !out_valid || out_ready;
endmodule
`default_nettype wire
